FILE: rtl/core/drp_pkg.sv
// ----------------------------------------------------------------------------
// drp_pkg
// Types and constants shared by the detection response parser.
// ----------------------------------------------------------------------------
package drp_pkg;

    localparam logic [7:0] SYNC_BYTE   = 8'hFE;
    localparam logic [7:0] STATUS_OK   = 8'h00;

    localparam logic [2:0] PH_WAIT     = 3'd0;
    localparam logic [2:0] PH_STATUS   = 3'd1;
    localparam logic [2:0] PH_LENGTH   = 3'd2;
    localparam logic [2:0] PH_COUNTS   = 3'd3;
    localparam logic [2:0] PH_FIELDS   = 3'd4;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_SYNC    = 2'd1;
    localparam logic [1:0] ERR_STATUS  = 2'd2;

    localparam logic [1:0] KIND_BODY   = 2'd0;
    localparam logic [1:0] KIND_HAND   = 2'd1;
    localparam logic [1:0] KIND_FACE   = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam int unsigned NUM_FIELDS = 24;
    localparam logic [4:0] NO_FIELD    = 5'd24;
    localparam logic [4:0] FC_SIZE     = 5'd2;
    localparam logic [4:0] FC_CONF     = 5'd3;
    localparam logic [4:0] FC_AGE      = 5'd8;
    localparam logic [4:0] FC_AGE_CONF = 5'd9;
    localparam logic [4:0] FC_SEX      = 5'd10;
    localparam logic [4:0] FC_SEX_CONF = 5'd11;
    localparam logic [4:0] FC_GAZE_H   = 5'd12;
    localparam logic [4:0] FC_GAZE_V   = 5'd13;
    localparam logic [4:0] FC_EYE_L    = 5'd14;
    localparam logic [4:0] FC_EYE_R    = 5'd15;
    localparam logic [4:0] FC_EXPR_0   = 5'd16;
    localparam logic [4:0] FC_EXPR_T   = 5'd21;
    localparam logic [4:0] FC_SCORE    = 5'd23;

    localparam int unsigned OPT_DIR    = 3;
    localparam int unsigned OPT_AGE    = 4;
    localparam int unsigned OPT_SEX    = 5;
    localparam int unsigned OPT_GAZE   = 6;
    localparam int unsigned OPT_EYE    = 7;
    localparam int unsigned OPT_EXPR   = 0;
    localparam int unsigned OPT_RECOG  = 1;

    localparam logic CFG_FACE_OPTIONS  = 1'b0;
    localparam logic CFG_EXTRA_OPTIONS = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } in_t;

    typedef struct packed {
        logic [1:0]  object_kind;
        logic [7:0]  object_number;
        logic [4:0]  field_code;
        logic [15:0] field_value;
        logic [1:0]  error_code;
        logic        done_res;
    } out_t;

endpackage

FILE: rtl/core/drp_parser.sv
// ----------------------------------------------------------------------------
// drp_parser
// Parse state and per-byte decode; yields at most one result per beat.
// ----------------------------------------------------------------------------
module drp_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          beat_en,
    input  drp_pkg::in_t  beat,
    input  logic [7:0]    face_options,
    input  logic [1:0]    extra_options,
    output logic          res_valid,
    output drp_pkg::out_t res
);
    import drp_pkg::*;

    logic [2:0] phase_reg, phase_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [7:0] body_cnt_reg, body_cnt_next;
    logic [7:0] hand_cnt_reg, hand_cnt_next;
    logic [7:0] face_cnt_reg, face_cnt_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] idx_reg, idx_next;
    logic [4:0] field_reg, field_next;
    logic [7:0] low_reg, low_next;

    logic [4:0] nxt_field;
    logic [7:0] idx_inc;
    logic [2:0] cnt_inc;
    logic       seek0_ok, seekn_ok;
    logic [1:0] seek0_kind, seekn_kind;

    function automatic logic [7:0] count_of(input logic [1:0] k, input logic [7:0] bc,
                                            input logic [7:0] hc, input logic [7:0] fc);
        logic [7:0] c;
        case (k)
            KIND_BODY: c = bc;
            KIND_HAND: c = hc;
            KIND_FACE: c = fc;
            default:   c = 8'd0;
        endcase
        return c;
    endfunction

    function automatic logic code_enabled(input logic [4:0] c, input logic [7:0] fo,
                                          input logic [1:0] eo);
        logic en;
        if (c <= FC_CONF)          en = 1'b1;
        else if (c < FC_AGE)       en = fo[OPT_DIR];
        else if (c < FC_SEX)       en = fo[OPT_AGE];
        else if (c < FC_GAZE_H)    en = fo[OPT_SEX];
        else if (c < FC_EYE_L)     en = fo[OPT_GAZE];
        else if (c < FC_EXPR_0)    en = fo[OPT_EYE];
        else if (c <= FC_EXPR_T)   en = eo[OPT_EXPR];
        else if (c <= FC_SCORE)    en = eo[OPT_RECOG];
        else                       en = 1'b0;
        return en;
    endfunction

    function automatic logic code_is_byte(input logic [4:0] c);
        return (c == FC_AGE) || (c == FC_SEX) || (c == FC_GAZE_H) || (c == FC_GAZE_V) ||
               ((c >= FC_EXPR_0) && (c <= FC_EXPR_T));
    endfunction

    // first kind at or above 'from' with a nonzero count
    function automatic logic [2:0] seek(input logic [1:0] from, input logic [7:0] bc,
                                        input logic [7:0] hc, input logic [7:0] fc);
        logic [2:0] r;
        r = {1'b0, KIND_NONE};
        if (from <= KIND_FACE && fc != 8'd0) r = {1'b1, KIND_FACE};
        if (from <= KIND_HAND && hc != 8'd0) r = {1'b1, KIND_HAND};
        if (from == KIND_BODY && bc != 8'd0) r = {1'b1, KIND_BODY};
        return r;
    endfunction

    always_comb begin
        nxt_field = NO_FIELD;
        if (kind_reg != KIND_FACE) begin
            if (field_reg < FC_CONF) nxt_field = field_reg + 5'd1;
        end else begin
            for (int n = NUM_FIELDS - 1; n >= 0; n--) begin
                if (5'(n) > field_reg && code_enabled(5'(n), face_options, extra_options)) begin
                    nxt_field = 5'(n);
                end
            end
        end
    end

    assign idx_inc = idx_reg + 8'd1;
    assign cnt_inc = cnt_reg + 3'd1;
    assign {seek0_ok, seek0_kind} = seek(KIND_BODY, body_cnt_reg, hand_cnt_reg, face_cnt_reg);
    assign {seekn_ok, seekn_kind} = seek(kind_reg + 2'd1, body_cnt_reg, hand_cnt_reg,
                                         face_cnt_reg);

    always_comb begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        body_cnt_next = body_cnt_reg;
        hand_cnt_next = hand_cnt_reg;
        face_cnt_next = face_cnt_reg;
        kind_next     = kind_reg;
        idx_next      = idx_reg;
        field_next    = field_reg;
        low_next      = low_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (beat.frame_start) begin
            cnt_next      = 3'd0;
            body_cnt_next = 8'd0;
            hand_cnt_next = 8'd0;
            face_cnt_next = 8'd0;
            kind_next     = KIND_BODY;
            idx_next      = 8'd0;
            field_next    = 5'd0;
            low_next      = 8'd0;
            if (beat.rx_byte != SYNC_BYTE) begin
                phase_next     = PH_WAIT;
                res_valid      = 1'b1;
                res.error_code = ERR_SYNC;
                res.done_res   = 1'b1;
            end else begin
                phase_next = PH_STATUS;
            end
        end else begin
            case (phase_reg)
                PH_STATUS: begin
                    if (beat.rx_byte != STATUS_OK) begin
                        phase_next     = PH_WAIT;
                        res_valid      = 1'b1;
                        res.error_code = ERR_STATUS;
                        res.done_res   = 1'b1;
                    end else begin
                        phase_next = PH_LENGTH;
                        cnt_next   = 3'd0;
                    end
                end
                PH_LENGTH: begin
                    cnt_next = cnt_inc;
                    if (cnt_inc >= 3'd4) begin
                        phase_next = PH_COUNTS;
                        cnt_next   = 3'd0;
                    end
                end
                PH_COUNTS: begin
                    if (cnt_reg == 3'd0) body_cnt_next = beat.rx_byte;
                    else if (cnt_reg == 3'd1) hand_cnt_next = beat.rx_byte;
                    else if (cnt_reg == 3'd2) face_cnt_next = beat.rx_byte;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= 3'd4) begin
                        cnt_next = 3'd0;
                        if (seek0_ok) begin
                            kind_next  = seek0_kind;
                            idx_next   = 8'd0;
                            field_next = 5'd0;
                            phase_next = PH_FIELDS;
                        end else begin
                            phase_next   = PH_WAIT;
                            res_valid    = 1'b1;
                            res.done_res = 1'b1;
                        end
                    end
                end
                PH_FIELDS: begin
                    if (!code_is_byte(field_reg) && cnt_reg == 3'd0) begin
                        low_next = beat.rx_byte;
                        cnt_next = 3'd1;
                    end else begin
                        res_valid         = 1'b1;
                        res.object_kind   = kind_reg;
                        res.object_number = idx_reg;
                        res.field_code    = field_reg;
                        res.field_value   = code_is_byte(field_reg) ? {8'd0, beat.rx_byte}
                                                                    : {beat.rx_byte, low_reg};
                        cnt_next = 3'd0;
                        if (nxt_field != NO_FIELD) begin
                            field_next = nxt_field;
                        end else if (idx_inc < count_of(kind_reg, body_cnt_reg,
                                                        hand_cnt_reg, face_cnt_reg)) begin
                            idx_next   = idx_inc;
                            field_next = 5'd0;
                        end else if (seekn_ok) begin
                            kind_next  = seekn_kind;
                            idx_next   = 8'd0;
                            field_next = 5'd0;
                        end else begin
                            idx_next     = idx_inc;
                            phase_next   = PH_WAIT;
                            res.done_res = 1'b1;
                        end
                    end
                end
                default: begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_WAIT;
            cnt_reg      <= 3'd0;
            body_cnt_reg <= 8'd0;
            hand_cnt_reg <= 8'd0;
            face_cnt_reg <= 8'd0;
            kind_reg     <= KIND_BODY;
            idx_reg      <= 8'd0;
            field_reg    <= 5'd0;
            low_reg      <= 8'd0;
        end else if (beat_en) begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            body_cnt_reg <= body_cnt_next;
            hand_cnt_reg <= hand_cnt_next;
            face_cnt_reg <= face_cnt_next;
            kind_reg     <= kind_next;
            idx_reg      <= idx_next;
            field_reg    <= field_next;
            low_reg      <= low_next;
        end
    end

endmodule

FILE: rtl/core/detection_response_parser_top.sv
// ----------------------------------------------------------------------------
// detection_response_parser_top
// Byte-serial parser for an object-detection response from a camera module.
//
// Input channel (s_*): one response byte per beat, with frame_start marking
// the first byte of a response. Result channel (m_*): tagged field values,
// error reports and the done flag, at most one result beat per input beat.
// Config channel (cfg_*): index 0 face_options, index 1 extra_options;
// always ready, written one beat per cycle.
// Path: input register, then decode, then result register driving m_valid.
// Throughput: one byte per cycle while no result is pending or m_ready is
// high, set by the single decode stage.
// Reset: parser waits for a frame start, option registers clear to zero,
// no result is pending.
// Stall: when m_ready is low the result register holds; an empty input
// register takes one more byte, then s_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module detection_response_parser_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  drp_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output drp_pkg::out_t  m_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic           cfg_index,
    input  logic [7:0]     cfg_data
);
    import drp_pkg::*;

    in_t        in_data_reg;
    logic       in_valid_reg;
    out_t       out_data_reg;
    logic       out_valid_reg;
    logic [7:0] face_opt_reg;
    logic [1:0] extra_opt_reg;

    logic       fire;
    logic       res_valid;
    out_t       res;

    assign fire      = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    drp_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .beat_en       (fire),
        .beat          (in_data_reg),
        .face_options  (face_opt_reg),
        .extra_options (extra_opt_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            out_data_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            face_opt_reg  <= 8'd0;
            extra_opt_reg <= 2'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FACE_OPTIONS:  face_opt_reg  <= cfg_data;
                CFG_EXTRA_OPTIONS: extra_opt_reg <= cfg_data[1:0];
                default:           face_opt_reg  <= face_opt_reg;
            endcase
        end
    end

endmodule
